>>> sv/mtb_pkg.sv
// Package for the mean threshold binarizer.
// Holds widths, register indexes, pass codes and the dimension clamp function.
// No dependencies.
`timescale 1ns / 1ps

package mtb_pkg;

  localparam int MAX_DIM         = 4096;
  localparam int DIM_W           = 13;
  localparam int POS_W           = 12;
  localparam int CHAN_W          = 8;
  localparam int GRAY_SUM_W      = 10;
  localparam int GRAY_PROD_W     = 20;
  localparam int ROW_SUM_W       = 20;
  localparam int FRAME_SUM_W     = 32;
  localparam int DIV_W           = 32;
  localparam int CNT_W           = 5;
  localparam int ROW_DIV_STEPS   = ROW_SUM_W;
  localparam int FRAME_DIV_STEPS = FRAME_SUM_W;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic FUNC_MEASURE  = 1'b0;
  localparam logic FUNC_BINARIZE = 1'b1;

  localparam logic [CHAN_W-1:0] LEVEL_WHITE = 8'hff;
  localparam logic [CHAN_W-1:0] LEVEL_BLACK = 8'h00;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  // Reciprocal of three scaled by 2^11; exact floor for sums below 2048.
  localparam logic [10:0] RECIP3       = 11'd683;
  localparam int          RECIP3_SHIFT = 11;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> sv/mtb_if.sv
// Stream interfaces for the mean threshold binarizer: pixel words in, result words out.
// Depends on mtb_pkg.
`timescale 1ns / 1ps

interface mtb_pix_if;
  import mtb_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAN_W-1:0] chan0;
  logic [CHAN_W-1:0] chan1;
  logic [CHAN_W-1:0] chan2;
  modport source (output valid, func, chan0, chan1, chan2, input ready);
  modport sink   (input valid, func, chan0, chan1, chan2, output ready);
endinterface

interface mtb_res_if;
  import mtb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] level;
  logic [CHAN_W-1:0] threshold_used;
  logic              frame_end;
  modport source (output valid, level, threshold_used, frame_end, input ready);
  modport sink   (input valid, level, threshold_used, frame_end, output ready);
endinterface

>>> sv/mean_threshold_binarizer_top.sv
// Top level of the mean threshold binarizer.
// Depends on mtb_pkg and the stream interfaces in mtb_if.sv.
`timescale 1ns / 1ps

// The frame is sent twice on the pix channel. Words with func 0 measure: their
// gray values build row means and, at frame end, the threshold. They give no
// result. Words with func 1 are binarized and give one word on the res channel
// in the cycle after acceptance, held in an output register until res.ready.
// A word is taken at a rising clk edge with valid and ready high.
// Throughput: one word per cycle, except that a measure word closing a row
// holds pix.ready low while the shared subtract unit divides the row sum by
// the width, and a word closing the frame keeps it low longer, until the
// frame sum has been divided by the height.
// pix.ready is also low while a result waits and the receiver stalls.
// frame_width and frame_height are written through cfg_we, cfg_index and
// cfg_data; the user writes them only while the block is idle, which the
// block itself does not enforce. Unknown indexes are ignored. Synchronous reset
// on rst restores 640 by 480, clears sums, position, threshold and the output valid.
module mean_threshold_binarizer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtb_pkg::DIM_W-1:0]     cfg_data,
  mtb_pix_if.sink                       pix,
  mtb_res_if.source                     res
);
  import mtb_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROWDIV = 2'd1;
  localparam logic [1:0] ST_FRMDIV = 2'd2;

  logic [1:0]             state;
  logic [DIM_W-1:0]       frame_width;
  logic [DIM_W-1:0]       frame_height;
  logic [ROW_SUM_W-1:0]   row_gray_sum;
  logic [FRAME_SUM_W-1:0] frame_row_mean_sum;
  logic [POS_W-1:0]       column_index;
  logic [POS_W-1:0]       row_index;
  logic [CHAN_W-1:0]      threshold;
  logic                   frame_close;
  logic [DIM_W-1:0]       height_lat;

  logic [DIV_W-1:0]       div_q;
  logic [DIM_W-1:0]       div_rem;
  logic [DIM_W-1:0]       div_dvsr;
  logic [CNT_W-1:0]       div_cnt;

  logic                   res_valid;
  logic [CHAN_W-1:0]      res_level;
  logic [CHAN_W-1:0]      res_threshold;
  logic                   res_frame_end;

  logic [GRAY_SUM_W-1:0]  gray_sum;
  logic [GRAY_PROD_W-1:0] gray_prod;
  logic [CHAN_W-1:0]      gray;
  logic [ROW_SUM_W-1:0]   row_sum_add;
  logic [DIM_W-1:0]       w_eff;
  logic [DIM_W-1:0]       h_eff;
  logic                   col_last;
  logic                   row_last;
  logic                   accept;
  logic                   any_above;
  logic [DIM_W:0]         div_trial;
  logic                   div_ge;
  logic [DIM_W:0]         div_diff;
  logic [DIM_W-1:0]       div_rem_next;
  logic [DIV_W-1:0]       div_q_next;
  logic [FRAME_SUM_W-1:0] fsum_next;

  assign pix.ready          = (state == ST_IDLE) && (!res_valid || res.ready);
  assign accept             = pix.valid && pix.ready;
  assign res.valid          = res_valid;
  assign res.level          = res_level;
  assign res.threshold_used = res_threshold;
  assign res.frame_end      = res_frame_end;

  always_comb begin
    gray_sum    = GRAY_SUM_W'(pix.chan0) + GRAY_SUM_W'(pix.chan1) + GRAY_SUM_W'(pix.chan2);
    gray_prod   = GRAY_PROD_W'(gray_sum) * GRAY_PROD_W'(RECIP3);
    gray        = gray_prod[RECIP3_SHIFT +: CHAN_W];
    row_sum_add = row_gray_sum + ROW_SUM_W'(gray);
    w_eff       = eff_dim(frame_width);
    h_eff       = eff_dim(frame_height);
    col_last    = ({1'b0, column_index} + DIM_W'(1)) >= w_eff;
    row_last    = ({1'b0, row_index} + DIM_W'(1)) >= h_eff;
    any_above   = (pix.chan0 > threshold) || (pix.chan1 > threshold) ||
                  (pix.chan2 > threshold);

    // One restoring division step: shift in the next dividend bit and try the subtract.
    div_trial    = {div_rem, div_q[DIV_W-1]};
    div_diff     = div_trial - {1'b0, div_dvsr};
    div_ge       = div_trial >= {1'b0, div_dvsr};
    div_rem_next = div_ge ? div_diff[DIM_W-1:0] : div_trial[DIM_W-1:0];
    div_q_next   = {div_q[DIV_W-2:0], div_ge};
    fsum_next    = frame_row_mean_sum + FRAME_SUM_W'(div_q_next[ROW_SUM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      frame_width        <= RESET_WIDTH;
      frame_height       <= RESET_HEIGHT;
      row_gray_sum       <= '0;
      frame_row_mean_sum <= '0;
      column_index       <= '0;
      row_index          <= '0;
      threshold          <= '0;
      frame_close        <= 1'b0;
      div_cnt            <= '0;
      res_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end

      if (res_valid && res.ready && !(accept && pix.func == FUNC_BINARIZE)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            column_index <= col_last ? '0 : column_index + POS_W'(1);
            if (col_last) begin
              row_index <= row_last ? '0 : row_index + POS_W'(1);
            end
            if (pix.func == FUNC_MEASURE) begin
              if (col_last) begin
                row_gray_sum <= '0;
                div_q        <= {row_sum_add, {(DIV_W - ROW_SUM_W){1'b0}}};
                div_rem      <= '0;
                div_dvsr     <= w_eff;
                div_cnt      <= CNT_W'(ROW_DIV_STEPS - 1);
                frame_close  <= row_last;
                height_lat   <= h_eff;
                state        <= ST_ROWDIV;
              end else begin
                row_gray_sum <= row_sum_add;
              end
            end else begin
              res_valid     <= 1'b1;
              res_level     <= any_above ? LEVEL_WHITE : LEVEL_BLACK;
              res_threshold <= threshold;
              res_frame_end <= col_last && row_last;
            end
          end
        end
        ST_ROWDIV: begin
          if (div_cnt == '0) begin
            if (frame_close) begin
              div_q              <= fsum_next;
              div_rem            <= '0;
              div_dvsr           <= height_lat;
              div_cnt            <= CNT_W'(FRAME_DIV_STEPS - 1);
              frame_row_mean_sum <= '0;
              state              <= ST_FRMDIV;
            end else begin
              frame_row_mean_sum <= fsum_next;
              state              <= ST_IDLE;
            end
          end else begin
            div_q   <= div_q_next;
            div_rem <= div_rem_next;
            div_cnt <= div_cnt - CNT_W'(1);
          end
        end
        ST_FRMDIV: begin
          if (div_cnt == '0) begin
            threshold <= div_q_next[CHAN_W-1:0];
            state     <= ST_IDLE;
          end else begin
            div_q   <= div_q_next;
            div_rem <= div_rem_next;
            div_cnt <= div_cnt - CNT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/mtb_checker.sv
// Port-level checks for the mean threshold binarizer, bound to its top level.
// Depends on mtb_pkg and mean_threshold_binarizer_top.
`timescale 1ns / 1ps

module mtb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pix_valid,
  input logic                      pix_ready,
  input logic                      pix_func,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [mtb_pkg::CHAN_W-1:0] level,
  input logic [mtb_pkg::CHAN_W-1:0] threshold_used,
  input logic                      frame_end
);
  import mtb_pkg::*;

  a_level_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (level == LEVEL_WHITE || level == LEVEL_BLACK))
    else $error("result level is neither white nor black");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable(level) && $stable(threshold_used) && $stable(frame_end))
    else $error("stalled result word changed");

  a_binarize_latency: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && pix_func == FUNC_BINARIZE |=> res_valid)
    else $error("binarize word gave no result in the next cycle");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !pix_ready)
    else $error("input taken while a result is stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind mean_threshold_binarizer_top mtb_checker u_mtb_checker (
  .clk            (clk),
  .rst            (rst),
  .pix_valid      (pix.valid),
  .pix_ready      (pix.ready),
  .pix_func       (pix.func),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .level          (res.level),
  .threshold_used (res.threshold_used),
  .frame_end      (res.frame_end)
);

>>> tb/sv/tb_mean_threshold_binarizer_top.sv
// Testbench for the mean threshold binarizer: streams measure and binarize frames with random
// gaps and stalls, predicts every result word and checks it field by field.
// Depends on mtb_pkg, the stream interfaces in mtb_if.sv and mean_threshold_binarizer_top.
`timescale 1ns / 1ps

module tb_mean_threshold_binarizer_top;
  import mtb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PCT     = 14;
  localparam int RANDOM_WORDS = 950;
  localparam int WIDE_DIM     = 300;

  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] level;
    logic [CHAN_W-1:0] threshold_used;
    logic              frame_end;
  } level_word_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  mtb_pix_if pix ();
  mtb_res_if res ();

  mean_threshold_binarizer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .res       (res)
  );

  pixel_t      pending_pixels[$];
  level_word_t expected_levels[$];
  pixel_t      pixel_on_bus;
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_request;
  bit          no_gaps;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  int unsigned      row_gray_acc;
  int unsigned      frame_mean_acc;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [CHAN_W-1:0] cur_threshold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    int unsigned r;
    r = v;
    if (r == 0) begin
      r = 1;
    end else if (r > MAX_DIM) begin
      r = MAX_DIM;
    end
    return r;
  endfunction

  task automatic track_pixel(input pixel_t p);
    int unsigned w;
    int unsigned h;
    bit          row_done;
    bit          frame_done;
    level_word_t r;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    row_done = 1'b0;
    frame_done = 1'b0;
    if (p.func == FUNC_MEASURE) begin
      row_gray_acc += (int'(p.chan0) + int'(p.chan1) + int'(p.chan2)) / 3;
    end
    if (col_pos + 1 < w) begin
      col_pos++;
    end else begin
      col_pos = 0;
      row_done = 1'b1;
      if (row_pos + 1 < h) begin
        row_pos++;
      end else begin
        row_pos = 0;
        frame_done = 1'b1;
      end
    end
    if (p.func == FUNC_MEASURE) begin
      if (row_done) begin
        frame_mean_acc += row_gray_acc / w;
        row_gray_acc = 0;
      end
      if (frame_done) begin
        cur_threshold = CHAN_W'(frame_mean_acc / h);
        frame_mean_acc = 0;
      end
    end else begin
      r.level = (p.chan0 > cur_threshold || p.chan1 > cur_threshold ||
                 p.chan2 > cur_threshold) ? LEVEL_WHITE : LEVEL_BLACK;
      r.threshold_used = cur_threshold;
      r.frame_end = frame_done;
      expected_levels.push_back(r);
    end
  endtask

  function automatic logic [CHAN_W-1:0] chan_near(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  task automatic queue_one(input logic fn, input int c0, input int c1, input int c2);
    pixel_t p;
    p.func = fn;
    p.chan0 = CHAN_W'(c0);
    p.chan1 = CHAN_W'(c1);
    p.chan2 = CHAN_W'(c2);
    pending_pixels.push_back(p);
    words_queued++;
  endtask

  task automatic queue_pixels(input logic fn, input bit mixed, input int count,
                              input int center, input int spread);
    pixel_t p;
    for (int i = 0; i < count; i++) begin
      p.func = mixed ? logic'($urandom_range(1)) : fn;
      p.chan0 = chan_near(center, spread);
      p.chan1 = chan_near(center, spread);
      p.chan2 = chan_near(center, spread);
      pending_pixels.push_back(p);
    end
    words_queued += count;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_W'(val);
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = DIM_W'(val);
    end else if (idx == CFG_FRAME_HEIGHT) begin
      height_reg = DIM_W'(val);
    end
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    while (words_taken != words_queued || expected_levels.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        track_pixel(pixel_on_bus);
        words_taken++;
      end
      if (!pix.valid || pix.ready) begin
        if (pending_pixels.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          pixel_on_bus = pending_pixels.pop_front();
          pix.valid <= 1'b1;
          pix.func <= pixel_on_bus.func;
          pix.chan0 <= pixel_on_bus.chan0;
          pix.chan1 <= pixel_on_bus.chan1;
          pix.chan2 <= pixel_on_bus.chan2;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    level_word_t want;
    if (rst) begin
      res.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_levels.size() == 0) begin
          $error("unexpected result word: level %0d threshold_used %0d frame_end %0d",
                 res.level, res.threshold_used, res.frame_end);
          fail_count++;
        end else begin
          want = expected_levels.pop_front();
          if (res.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, res.level);
            fail_count++;
          end
          if (res.threshold_used !== want.threshold_used) begin
            $error("threshold_used: expected %0d, actual %0d",
                   want.threshold_used, res.threshold_used);
            fail_count++;
          end
          if (res.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", want.frame_end, res.frame_end);
            fail_count++;
          end
        end
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int          center;
    int          spread;
    int          kind;
    int          phase;
    int          random_words;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.func = FUNC_MEASURE;
    pix.chan0 = '0;
    pix.chan1 = '0;
    pix.chan2 = '0;
    res.ready = 1'b0;
    hold_request = 1'b0;
    no_gaps = 1'b0;
    fail_count = 0;
    words_queued = 0;
    words_taken = 0;
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    row_gray_acc = 0;
    frame_mean_acc = 0;
    col_pos = 0;
    row_pos = 0;
    cur_threshold = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Right after reset the threshold is zero; the position also runs on past the new sizes.
    queue_one(FUNC_BINARIZE, 0, 0, 0);
    queue_one(FUNC_BINARIZE, 1, 0, 0);
    queue_one(FUNC_BINARIZE, 0, 0, 1);
    settle();
    put_reg(CFG_FRAME_WIDTH, 0);
    put_reg(CFG_FRAME_HEIGHT, 0);
    close_writes();
    queue_one(FUNC_MEASURE, 255, 255, 255);
    queue_one(FUNC_BINARIZE, 255, 255, 255);
    queue_one(FUNC_BINARIZE, 255, 254, 0);
    settle();
    put_reg(CFG_FRAME_WIDTH, 2);
    put_reg(CFG_FRAME_HEIGHT, 2);
    put_reg(CFG_SPARE_A, 8191);
    put_reg(CFG_SPARE_B, 0);
    close_writes();
    queue_one(FUNC_MEASURE, 255, 255, 254);
    queue_one(FUNC_MEASURE, 0, 0, 0);
    queue_one(FUNC_MEASURE, 255, 0, 0);
    queue_one(FUNC_MEASURE, 1, 1, 2);
    queue_one(FUNC_BINARIZE, 85, 85, 85);
    queue_one(FUNC_BINARIZE, 86, 0, 0);
    queue_one(FUNC_BINARIZE, 0, 0, 86);
    queue_one(FUNC_BINARIZE, 0, 255, 0);
    settle();
    put_reg(CFG_FRAME_WIDTH, 3);
    put_reg(CFG_FRAME_HEIGHT, 1);
    close_writes();
    queue_one(FUNC_MEASURE, 200, 100, 50);
    queue_one(FUNC_BINARIZE, 120, 120, 120);
    queue_one(FUNC_MEASURE, 30, 60, 90);
    queue_one(FUNC_BINARIZE, 115, 0, 0);
    queue_one(FUNC_BINARIZE, 116, 0, 0);
    queue_one(FUNC_BINARIZE, 0, 117, 0);

    // A wide row, then a narrower width that leaves the column past the end.
    settle();
    put_reg(CFG_FRAME_WIDTH, WIDE_DIM);
    put_reg(CFG_FRAME_HEIGHT, 1);
    close_writes();
    queue_pixels(FUNC_MEASURE, 1'b0, WIDE_DIM, 180, 75);
    queue_pixels(FUNC_BINARIZE, 1'b0, 64, 180, 75);
    settle();
    put_reg(CFG_FRAME_WIDTH, 2);
    close_writes();
    queue_pixels(FUNC_BINARIZE, 1'b0, 3, 128, 128);

    // A tall frame of single pixel rows.
    settle();
    put_reg(CFG_FRAME_WIDTH, 1);
    put_reg(CFG_FRAME_HEIGHT, WIDE_DIM);
    close_writes();
    queue_pixels(FUNC_MEASURE, 1'b0, WIDE_DIM, 60, 60);
    queue_pixels(FUNC_BINARIZE, 1'b0, 8, 60, 60);

    // Oversized sizes clamp; then both sizes drop below the current position.
    settle();
    put_reg(CFG_FRAME_WIDTH, 8191);
    put_reg(CFG_FRAME_HEIGHT, 8191);
    close_writes();
    queue_pixels(FUNC_MEASURE, 1'b0, 40, 128, 128);
    settle();
    put_reg(CFG_FRAME_HEIGHT, 2);
    put_reg(CFG_FRAME_WIDTH, 3);
    close_writes();
    queue_pixels(FUNC_MEASURE, 1'b0, 9, 128, 128);
    queue_pixels(FUNC_BINARIZE, 1'b0, 6, 128, 128);

    phase = 0;
    random_words = 0;
    while (random_words < RANDOM_WORDS || phase <= 8) begin
      settle();
      no_gaps = 1'b0;
      w = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
      h = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1);
      if (phase == 4) begin
        w = 16;
        h = 8;
      end
      if ($urandom_range(1) == 0) begin
        put_reg(CFG_FRAME_WIDTH, ($urandom_range(19) == 0) ? 0 : w);
        put_reg(CFG_FRAME_HEIGHT, ($urandom_range(19) == 0) ? 0 : h);
      end else begin
        put_reg(CFG_FRAME_HEIGHT, h);
        put_reg(CFG_FRAME_WIDTH, w);
      end
      if ($urandom_range(9) == 0) begin
        put_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom_range(8191));
      end
      close_writes();
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      center = $urandom_range(255);
      case ($urandom_range(3))
        0: spread = 0;
        1: spread = 2;
        2: spread = 16;
        default: spread = 255;
      endcase
      kind = $urandom_range(99);
      if (phase == 4) begin
        no_gaps = 1'b1;
        kind = 0;
      end
      if (phase == 8) begin
        hold_request = 1'b1;
        queue_pixels(FUNC_BINARIZE, 1'b0, 40, center, spread);
        random_words += 40;
      end else if (kind < 70) begin
        queue_pixels(FUNC_MEASURE, 1'b0, w * h, center, spread);
        queue_pixels(FUNC_BINARIZE, 1'b0, w * h, center, spread);
        random_words += 2 * w * h;
      end else if (kind < 85) begin
        n = $urandom_range(30, 5);
        queue_pixels(FUNC_MEASURE, 1'b1, n, center, spread);
        random_words += n;
      end else begin
        n = $urandom_range(w * h - 1);
        queue_pixels(FUNC_MEASURE, 1'b0, n, center, spread);
        random_words += n;
        n = $urandom_range(w * h);
        queue_pixels(FUNC_BINARIZE, 1'b0, n, center, spread);
        random_words += n;
      end
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
